FILE: sv/frame_geometric_remap_assert.svh
// Assertion macros for the frame remap block.
`ifndef FRAME_GEOMETRIC_REMAP_ASSERT_SVH
`define FRAME_GEOMETRIC_REMAP_ASSERT_SVH

// Same-cycle implication.
`define FRM_ASSERT_NOW(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication.
`define FRM_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

FILE: sv/frm_pkg.sv
// Shared constants for the frame remap block: mode and register codes, frame side, fill value, queue depth.
package frm_pkg;

    localparam int FRAME_SIDE_DEFAULT = 256;

    localparam logic [7:0] FILL_VALUE = 8'd255;

    localparam logic [4:0] MODE_IDENTITY   = 5'd0;
    localparam logic [4:0] MODE_FLIP_H     = 5'd1;
    localparam logic [4:0] MODE_FLIP_V     = 5'd2;
    localparam logic [4:0] MODE_ROT_90     = 5'd3;
    localparam logic [4:0] MODE_ROT_180    = 5'd4;
    localparam logic [4:0] MODE_ROT_270    = 5'd5;
    localparam logic [4:0] MODE_MIRROR_L   = 5'd6;
    localparam logic [4:0] MODE_MIRROR_R   = 5'd7;
    localparam logic [4:0] MODE_MIRROR_U   = 5'd8;
    localparam logic [4:0] MODE_MIRROR_D   = 5'd9;
    localparam logic [4:0] MODE_ENLARGE_Q1 = 5'd10;
    localparam logic [4:0] MODE_ENLARGE_Q2 = 5'd11;
    localparam logic [4:0] MODE_ENLARGE_Q3 = 5'd12;
    localparam logic [4:0] MODE_ENLARGE_Q4 = 5'd13;
    localparam logic [4:0] MODE_SHRINK_2   = 5'd14;
    localparam logic [4:0] MODE_SHRINK_3   = 5'd15;
    localparam logic [4:0] MODE_SHRINK_4   = 5'd16;
    localparam logic [4:0] MODE_CROP       = 5'd17;

    localparam logic [2:0] CFG_MODE        = 3'd0;
    localparam logic [2:0] CFG_CROP_TOP    = 3'd1;
    localparam logic [2:0] CFG_CROP_LEFT   = 3'd2;
    localparam logic [2:0] CFG_CROP_HEIGHT = 3'd3;
    localparam logic [2:0] CFG_CROP_WIDTH  = 3'd4;

    localparam logic [1:0] QUEUE_DEPTH = 2'd3;

endpackage

FILE: sv/frame_geometric_remap.sv
// Frame remap: one square grayscale frame in RAM, read back through a
// rotate/flip/mirror/enlarge/shrink/crop address mapping. One transaction is
// taken per cycle, writes and reads alike; a read result is offered once it has
// passed the single-port frame RAM's registered read and the output queue
// register. A three-entry output queue absorbs results while the consumer stalls;
// the input stalls only when that queue plus the read in flight would overflow.
// Frame contents are undefined until written; no clearing pass.
module frame_geometric_remap #(
    parameter int FRAME_SIDE = frm_pkg::FRAME_SIDE_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       op,
    input  logic [7:0] row,
    input  logic [7:0] col,
    input  logic [7:0] pixel_in,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] pixel_out,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data
);

    import frm_pkg::*;

    localparam int CW    = $clog2(FRAME_SIDE);
    localparam int XW    = ((CW > 8) ? CW : 8) + 2;
    localparam int AW    = 2 * CW;
    localparam int DEPTH = 1 << AW;

    localparam logic [XW-1:0] SIDE_X  = XW'(FRAME_SIDE);
    localparam logic [XW-1:0] LAST_X  = XW'(FRAME_SIDE - 1);
    localparam logic [XW-1:0] HALF_X  = XW'(FRAME_SIDE / 2);
    localparam logic [XW-1:0] UPPER_X = XW'(FRAME_SIDE - FRAME_SIDE / 2);
    localparam logic [XW-1:0] LIM2_X  = XW'(FRAME_SIDE / 2);
    localparam logic [XW-1:0] LIM3_X  = XW'(FRAME_SIDE / 3);
    localparam logic [XW-1:0] LIM4_X  = XW'(FRAME_SIDE / 4);

    logic [4:0] mode_reg;
    logic [7:0] crop_top_reg;
    logic [7:0] crop_left_reg;
    logic [7:0] crop_height_reg;
    logic [7:0] crop_width_reg;

    logic       s1_valid_reg;
    logic       s1_fill_reg;

    logic [7:0] q_data_reg [3];
    logic [1:0] q_wr_reg;
    logic [1:0] q_rd_reg;
    logic [1:0] q_count_reg;
    logic [1:0] q_count_next;

    logic [XW-1:0] r_x;
    logic [XW-1:0] c_x;
    logic [XW-1:0] src_r;
    logic [XW-1:0] src_c;
    logic          force_fill;
    logic          src_out;
    logic [8:0]    crop_bottom;
    logic [8:0]    crop_right;

    logic          accept;
    logic          wr_en;
    logic [AW-1:0] ram_addr;
    logic [7:0]    ram_rdata;
    logic [2:0]    occupancy;
    logic          push;
    logic          pop;

    assign r_x = XW'(row);
    assign c_x = XW'(col);
    assign crop_bottom = {1'b0, crop_top_reg} + {1'b0, crop_height_reg};
    assign crop_right  = {1'b0, crop_left_reg} + {1'b0, crop_width_reg};

    always_comb
    begin
        src_r      = r_x;
        src_c      = c_x;
        force_fill = 1'b0;
        case (mode_reg)
            MODE_FLIP_H:     src_c = LAST_X - c_x;
            MODE_FLIP_V:     src_r = LAST_X - r_x;
            MODE_ROT_90:
            begin
                src_r = LAST_X - c_x;
                src_c = r_x;
            end
            MODE_ROT_180:
            begin
                src_r = LAST_X - r_x;
                src_c = LAST_X - c_x;
            end
            MODE_ROT_270:
            begin
                src_r = c_x;
                src_c = LAST_X - r_x;
            end
            MODE_MIRROR_L:   src_c = (c_x >= UPPER_X) ? LAST_X - c_x : c_x;
            MODE_MIRROR_R:   src_c = (c_x < HALF_X) ? LAST_X - c_x : c_x;
            MODE_MIRROR_U:   src_r = (r_x >= UPPER_X) ? LAST_X - r_x : r_x;
            MODE_MIRROR_D:   src_r = (r_x < HALF_X) ? LAST_X - r_x : r_x;
            MODE_ENLARGE_Q1:
            begin
                src_r = r_x >> 1;
                src_c = c_x >> 1;
            end
            MODE_ENLARGE_Q2:
            begin
                src_r = r_x >> 1;
                src_c = HALF_X + (c_x >> 1);
            end
            MODE_ENLARGE_Q3:
            begin
                src_r = HALF_X + (r_x >> 1);
                src_c = c_x >> 1;
            end
            MODE_ENLARGE_Q4:
            begin
                src_r = HALF_X + (r_x >> 1);
                src_c = HALF_X + (c_x >> 1);
            end
            MODE_SHRINK_2:
            begin
                force_fill = (r_x >= LIM2_X) || (c_x >= LIM2_X);
                src_r      = (r_x << 1) + XW'(1);
                src_c      = (c_x << 1) + XW'(1);
            end
            MODE_SHRINK_3:
            begin
                force_fill = (r_x >= LIM3_X) || (c_x >= LIM3_X);
                src_r      = (r_x << 1) + r_x + XW'(2);
                src_c      = (c_x << 1) + c_x + XW'(2);
            end
            MODE_SHRINK_4:
            begin
                force_fill = (r_x >= LIM4_X) || (c_x >= LIM4_X);
                src_r      = (r_x << 2) + XW'(3);
                src_c      = (c_x << 2) + XW'(3);
            end
            MODE_CROP:
            begin
                force_fill = (row < crop_top_reg) || (col < crop_left_reg)
                          || ({1'b0, row} > crop_bottom) || ({1'b0, col} > crop_right);
            end
            default:
            begin
                src_r = r_x;
                src_c = c_x;
            end
        endcase
    end

    assign src_out = (src_r >= SIDE_X) || (src_c >= SIDE_X);

    assign occupancy = {1'b0, q_count_reg} + {2'b00, s1_valid_reg};
    assign in_ready  = (occupancy < {1'b0, QUEUE_DEPTH});
    assign accept    = in_valid && in_ready;
    assign wr_en     = accept && !op && (r_x < SIDE_X) && (c_x < SIDE_X);
    assign ram_addr  = op ? {src_r[CW-1:0], src_c[CW-1:0]}
                          : {r_x[CW-1:0], c_x[CW-1:0]};

    frm_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_frame_ram (
        .clk   (clk),
        .we    (wr_en),
        .addr  (ram_addr),
        .wdata (pixel_in),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_fill_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept && op;
            s1_fill_reg  <= force_fill || src_out;
        end
    end

    assign push = s1_valid_reg;
    assign pop  = out_valid && out_ready;

    always_comb
    begin
        q_count_next = q_count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_wr_reg    <= 2'd0;
            q_rd_reg    <= 2'd0;
            q_count_reg <= 2'd0;
        end
        else
        begin
            q_count_reg <= q_count_next;
            if (push)
            begin
                q_wr_reg <= (q_wr_reg == QUEUE_DEPTH - 2'd1) ? 2'd0 : q_wr_reg + 2'd1;
            end
            if (pop)
            begin
                q_rd_reg <= (q_rd_reg == QUEUE_DEPTH - 2'd1) ? 2'd0 : q_rd_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_data_reg[q_wr_reg] <= s1_fill_reg ? FILL_VALUE : ram_rdata;
        end
    end

    assign out_valid = (q_count_reg != 2'd0);
    assign pixel_out = q_data_reg[q_rd_reg];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_IDENTITY;
            crop_top_reg    <= 8'd0;
            crop_left_reg   <= 8'd0;
            crop_height_reg <= 8'd255;
            crop_width_reg  <= 8'd255;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_MODE:        mode_reg        <= cfg_data[4:0];
                CFG_CROP_TOP:    crop_top_reg    <= cfg_data;
                CFG_CROP_LEFT:   crop_left_reg   <= cfg_data;
                CFG_CROP_HEIGHT: crop_height_reg <= cfg_data;
                CFG_CROP_WIDTH:  crop_width_reg  <= cfg_data;
                default:         mode_reg        <= mode_reg;
            endcase
        end
    end

`include "frame_geometric_remap_assert.svh"

    `FRM_ASSERT_NOW(a_no_overflow, s1_valid_reg, q_count_reg < QUEUE_DEPTH, "queue overflow")
    `FRM_ASSERT_NEXT(a_read_issue, in_valid && in_ready && op, s1_valid_reg, "read lost")
    `FRM_ASSERT_NEXT(a_write_silent, in_valid && in_ready && !op, !s1_valid_reg, "write result")

endmodule

FILE: sv/frm_ram.sv
// Generic single-port RAM with registered read data.
module frm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule
